// ===== rtl/core/wrhi_pkg.sv =====
// ----------------------------------------------------------------------------
// Weak reference intern package
// Shared constants and types for the weak reference intern block.
// ----------------------------------------------------------------------------
package wrhi_pkg;

    localparam int HASH_SLOTS_DEF    = 2039;
    localparam int WEAK_CAPACITY_DEF = 1024;
    localparam logic [31:0] HASH_MULT = 32'h9E37_79BB;

    localparam logic [1:0] MODE_LOOKUP  = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_REBUILD = 2'd2;

    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_NIL     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_WRITTEN = 3'd4;
    localparam logic [2:0] ST_REBUILT = 3'd5;

    typedef enum logic [3:0] {
        S_INIT,      // clear sweep of the slot keys after reset
        S_IDLE,
        S_HASH,      // multiply result registered
        S_MOD,       // reciprocal multiply gives the quotient estimate
        S_SUBQ,      // quotient times slot count subtracted
        S_FIX,       // final conditional subtract gives the home slot
        S_READ,      // slot read issued
        S_PROBE,     // slot data available, compare
        S_WAITW,     // rebuild: weak table read issued
        S_RBREAD,    // rebuild: weak table data available
        S_CLEAR,     // rebuild: clear slot keys
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/wrhi_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface wrhi_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/weak_ref_hash_intern.sv =====
// ----------------------------------------------------------------------------
// Weak reference intern
// Maps 32-bit references to dense weak indices through a linear-probed hash.
// ----------------------------------------------------------------------------
// Lookup: multiply, quotient, subtract and fixup, then a slot read and compare
// per probe, then done. A nil lookup or a write goes straight to done.
// Rebuild: slot key clear sweep, then weak table entries are read, non-nil placed.
// One request at a time; the single slot memory port sets the probe rate.
// After reset the slot keys are swept to zero, one slot a cycle, while no
// request is accepted.
module weak_ref_hash_intern #(
    parameter int HASH_SLOTS    = wrhi_pkg::HASH_SLOTS_DEF,
    parameter int WEAK_CAPACITY = wrhi_pkg::WEAK_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    wrhi_if.sink        i_req,
    wrhi_if.source      o_rsp
);
    localparam int SW = $clog2(HASH_SLOTS);
    localparam int WW = (WEAK_CAPACITY > 1) ? $clog2(WEAK_CAPACITY) : 1;
    localparam int CW = $clog2(WEAK_CAPACITY + 1);
    localparam logic [SW:0] LAST_SLOT = (SW+1)'(HASH_SLOTS - 1);
    localparam logic [31:0] NSL = 32'(HASH_SLOTS);
    // The quotient estimate from this reciprocal is low by at most one.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / HASH_SLOTS);

    wrhi_pkg::t_state r_state, n_state;

    logic [31:0] r_nil;
    logic [31:0] r_key;      // reference being placed or looked up
    logic [1:0]  r_mode;
    logic [9:0]  r_ei;
    logic [31:0] r_h;        // hash under reduction
    logic [31:0] r_q;        // quotient estimate
    logic [SW:0] r_slot;
    logic [SW:0] r_cnt;      // probes done, or clear position
    logic [CW-1:0] r_wcnt;
    logic [CW-1:0] r_ri;     // rebuild entry index
    logic        r_rebuild;

    logic [31:0] slot_key  [HASH_SLOTS];
    logic [9:0]  slot_weak [HASH_SLOTS];
    logic [31:0] weak_tab  [WEAK_CAPACITY];
    logic [31:0] r_kq;
    logic [9:0]  r_wq;
    logic [31:0] r_tq;

    logic [10:0] r_oidx;
    logic [2:0]  r_ost;
    logic        r_ovalid;

    logic        slot_we;
    logic [SW-1:0] slot_wa;
    logic [31:0] slot_wk;
    logic        weak_we;
    logic        tab_we;
    logic [WW-1:0] tab_wa;

    // The one multiplier is shared by the hash and the remainder steps.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign i_req.ready = (r_state == wrhi_pkg::S_IDLE) && !r_ovalid;
    wire acc = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = {r_oidx, r_ost};

    logic [SW:0] slot_inc;
    assign slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    wire hit   = (r_kq == r_key);
    wire empty = (r_kq == r_nil);
    wire probes_left = (r_cnt < LAST_SLOT);
    wire room = (r_wcnt < CW'(WEAK_CAPACITY));

    always_comb begin
        mul_a = r_key;
        mul_b = wrhi_pkg::HASH_MULT;
        case (r_state)
            wrhi_pkg::S_MOD: begin
                mul_a = r_h;
                mul_b = RECIP;
            end
            wrhi_pkg::S_SUBQ: begin
                mul_a = r_q;
                mul_b = NSL;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wrhi_pkg::S_INIT:   if (r_cnt == LAST_SLOT) n_state = wrhi_pkg::S_IDLE;
            wrhi_pkg::S_IDLE: begin
                if (acc) begin
                    if (i_req.data[43])
                        n_state = wrhi_pkg::S_CLEAR;
                    else if (i_req.data[42])
                        n_state = wrhi_pkg::S_DONE;
                    else if (i_req.data[41:10] == r_nil)
                        n_state = wrhi_pkg::S_DONE;
                    else
                        n_state = wrhi_pkg::S_HASH;
                end
            end
            wrhi_pkg::S_HASH:   n_state = wrhi_pkg::S_MOD;
            wrhi_pkg::S_MOD:    n_state = wrhi_pkg::S_SUBQ;
            wrhi_pkg::S_SUBQ:   n_state = wrhi_pkg::S_FIX;
            wrhi_pkg::S_FIX:    n_state = wrhi_pkg::S_READ;
            wrhi_pkg::S_READ:   n_state = wrhi_pkg::S_PROBE;
            wrhi_pkg::S_PROBE: begin
                if (hit && !r_rebuild) n_state = wrhi_pkg::S_DONE;
                else if (empty || !probes_left)
                    n_state = r_rebuild ? wrhi_pkg::S_WAITW : wrhi_pkg::S_DONE;
                else n_state = wrhi_pkg::S_READ;
            end
            wrhi_pkg::S_CLEAR:
                if (r_cnt == LAST_SLOT) n_state = wrhi_pkg::S_WAITW;
            wrhi_pkg::S_WAITW:
                n_state = (r_ri < r_wcnt) ? wrhi_pkg::S_RBREAD : wrhi_pkg::S_DONE;
            wrhi_pkg::S_RBREAD:
                n_state = (r_tq != r_nil) ? wrhi_pkg::S_HASH : wrhi_pkg::S_WAITW;
            wrhi_pkg::S_DONE:   n_state = wrhi_pkg::S_IDLE;
            default:            n_state = wrhi_pkg::S_IDLE;
        endcase
    end

    // memory write controls
    always_comb begin
        slot_we = 1'b0;
        slot_wa = r_slot[SW-1:0];
        slot_wk = r_key;
        weak_we = 1'b0;
        tab_we  = 1'b0;
        tab_wa  = r_wcnt[WW-1:0];
        case (r_state)
            wrhi_pkg::S_INIT: begin
                slot_we = 1'b1;
                slot_wa = r_cnt[SW-1:0];
                slot_wk = '0;
            end
            wrhi_pkg::S_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = r_cnt[SW-1:0];
                slot_wk = r_nil;
            end
            wrhi_pkg::S_PROBE: begin
                if (!(hit && !r_rebuild) && empty && (r_rebuild || room)) begin
                    slot_we = 1'b1;
                    weak_we = 1'b1;
                    tab_we  = !r_rebuild;
                end
            end
            wrhi_pkg::S_DONE: begin
                if (r_mode == wrhi_pkg::MODE_WRITE && 32'(r_ei) < WEAK_CAPACITY) begin
                    tab_we = 1'b1;
                    tab_wa = WW'(r_ei);
                end
            end
            default: ;
        endcase
    end

    wire [9:0] new_idx = r_rebuild ? 10'(r_ri - 1'b1) : 10'(r_wcnt);

    always_ff @(posedge i_clk) begin
        if (slot_we) slot_key[slot_wa] <= slot_wk;
        if (weak_we) slot_weak[slot_wa] <= new_idx;
        if (tab_we)  weak_tab[tab_wa] <= r_key;
        r_kq <= slot_key[r_slot[SW-1:0]];
        r_wq <= slot_weak[r_slot[SW-1:0]];
        r_tq <= weak_tab[r_ri[WW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wrhi_pkg::S_INIT;
            r_nil     <= '0;
            r_cnt     <= '0;
            r_wcnt    <= '0;
            r_ovalid  <= 1'b0;
            r_rebuild <= 1'b0;
            r_ri      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_nil <= i_cfg_wdata;
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                wrhi_pkg::S_INIT:  r_cnt <= r_cnt + 1'b1;
                wrhi_pkg::S_IDLE: begin
                    if (acc) begin
                        r_mode    <= i_req.data[43:42];
                        r_key     <= i_req.data[41:10];
                        r_ei      <= i_req.data[9:0];
                        r_rebuild <= i_req.data[43];
                        r_cnt     <= '0;
                        r_ri      <= '0;
                        r_oidx    <= '1;
                        r_ost     <= wrhi_pkg::ST_NIL;
                    end
                end
                wrhi_pkg::S_HASH: r_h <= mul_p[31:0];
                wrhi_pkg::S_MOD:  r_q <= mul_p[63:32];
                // The product never exceeds the hash, so 32 bits suffice.
                wrhi_pkg::S_SUBQ: r_h <= r_h - mul_p[31:0];
                wrhi_pkg::S_FIX: begin
                    r_slot <= (r_h >= NSL) ? (SW+1)'(r_h - NSL) : (SW+1)'(r_h);
                    r_cnt  <= '0;
                end
                wrhi_pkg::S_PROBE: begin
                    r_slot <= slot_inc;
                    r_cnt  <= r_cnt + 1'b1;
                    if (!r_rebuild) begin
                        if (hit) begin
                            r_oidx <= {1'b0, r_wq};
                            r_ost  <= wrhi_pkg::ST_FOUND;
                        end else if (empty && room) begin
                            r_oidx <= 11'(r_wcnt);
                            r_ost  <= wrhi_pkg::ST_CREATED;
                            r_wcnt <= r_wcnt + 1'b1;
                        end else if (empty || !probes_left) begin
                            r_oidx <= '1;
                            r_ost  <= wrhi_pkg::ST_FULL;
                        end
                    end
                end
                wrhi_pkg::S_CLEAR: r_cnt <= r_cnt + 1'b1;
                wrhi_pkg::S_WAITW: ;
                wrhi_pkg::S_RBREAD: begin
                    r_key <= r_tq;
                    r_ri  <= r_ri + 1'b1;
                end
                wrhi_pkg::S_DONE: begin
                    r_ovalid <= 1'b1;
                    if (r_rebuild) begin
                        r_oidx <= '0;
                        r_ost  <= wrhi_pkg::ST_REBUILT;
                    end else if (r_mode == wrhi_pkg::MODE_WRITE) begin
                        r_ost  <= wrhi_pkg::ST_WRITTEN;
                        r_oidx <= (32'(r_ei) < WEAK_CAPACITY) ? {1'b0, r_ei} : '1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= CW'(WEAK_CAPACITY)) else $error("weak count over capacity");
    a_one_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !i_req.ready) else $error("request taken with result pending");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wcnt != $past(r_wcnt)) |-> (r_wcnt == $past(r_wcnt) + 1'b1))
        else $error("weak count jumped");
    a_slot_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrhi_pkg::S_PROBE) |-> (r_slot <= LAST_SLOT))
        else $error("slot out of range");
`endif
endmodule
